/* hw/rtl/ptbl_pkg.sv */
// Shared constants, types and command/status structs of the per-client token bucket limiter.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package ptbl_pkg;

	localparam int CLIENT_SLOTS = 16;
	localparam int SLOT_W       = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int GROUP        = 4;
	localparam int GROUPS       = (CLIENT_SLOTS + GROUP - 1) / GROUP;

	localparam int KEY_W        = 32;
	localparam int TIME_W       = 48;
	localparam int RATE_W       = 10;
	localparam int BURST_W      = 10;
	localparam int TOK_W        = 20;
	localparam int ELAPSED_W    = 21;
	localparam int PROD_W       = ELAPSED_W + RATE_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int OUT_SLOT_W   = 4;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 10;

	localparam logic [ELAPSED_W-1:0] ELAPSED_CAP       = ELAPSED_W'(1 << 20);
	localparam logic [TOK_W-1:0]     MILLI_PER_TOKEN   = TOK_W'(1000);
	localparam logic [RATE_W-1:0]    RATE_RESET        = RATE_W'(5);
	localparam logic [TOK_W-1:0]     BURST_MILLI_RESET = TOK_W'(10000);

	localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BURST_TOKENS = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_PICK,
		ST_DELTA,
		ST_SCALE,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic lookup;
		logic pick;
		logic delta;
		logic scale;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ptbl_req_if.sv */
// Request channel interface: valid/ready plus client key and timestamp.
// Depends on ptbl_pkg.
`default_nettype none

interface ptbl_req_if;
	logic                         valid;
	logic                         ready;
	logic [ptbl_pkg::KEY_W-1:0]   key_id;
	logic [ptbl_pkg::TIME_W-1:0]  time_ms;

	modport source (output valid, output key_id, output time_ms, input ready);
	modport sink   (input valid, input key_id, input time_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptbl_rsp_if.sv */
// Response channel interface: valid/ready plus verdict, slot and new-client flag.
// Depends on ptbl_pkg.
`default_nettype none

interface ptbl_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              allowed;
	logic [ptbl_pkg::OUT_SLOT_W-1:0]   slot_used;
	logic                              new_client;

	modport source (output valid, output allowed, output slot_used, output new_client,
		input ready);
	modport sink   (input valid, input allowed, input slot_used, input new_client,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptbl_cfg_if.sv */
// Configuration write channel interface: valid/ready plus register index and data.
// Depends on ptbl_pkg.
`default_nettype none

interface ptbl_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ptbl_pkg::CFG_IDX_W-1:0]     index;
	logic [ptbl_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptbl_ctrl.sv */
// Controller state machine: sequences lookup, pick, delta, scale and commit per request.
// Depends on ptbl_pkg; drives the datapath through ptbl_pkg::cmd_t.
`default_nettype none

module ptbl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  ptbl_pkg::sts_t       sts,
	output ptbl_pkg::cmd_t       cmd
);

	ptbl_pkg::state_t state_q;
	ptbl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptbl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptbl_pkg::ST_IDLE: begin
				if (req_valid) state_d = ptbl_pkg::ST_LOOKUP;
			end
			ptbl_pkg::ST_LOOKUP: state_d = ptbl_pkg::ST_PICK;
			ptbl_pkg::ST_PICK:   state_d = ptbl_pkg::ST_DELTA;
			ptbl_pkg::ST_DELTA:  state_d = ptbl_pkg::ST_SCALE;
			ptbl_pkg::ST_SCALE:  state_d = ptbl_pkg::ST_COMMIT;
			ptbl_pkg::ST_COMMIT: begin
				if (!sts.out_full) state_d = ptbl_pkg::ST_IDLE;
			end
			default: state_d = ptbl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ptbl_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ptbl_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
			ptbl_pkg::ST_PICK:   cmd.pick   = 1'b1;
			ptbl_pkg::ST_DELTA:  cmd.delta  = 1'b1;
			ptbl_pkg::ST_SCALE:  cmd.scale  = 1'b1;
			ptbl_pkg::ST_COMMIT: cmd.commit = !sts.out_full;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/ptbl_dp.sv */
// Datapath: slot table, key match, LRU search, refill arithmetic and response register.
// Depends on ptbl_pkg; steered by ptbl_ctrl through ptbl_pkg::cmd_t.
`default_nettype none

module ptbl_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  ptbl_pkg::cmd_t                           cmd,
	output ptbl_pkg::sts_t                           sts,
	input  wire logic [ptbl_pkg::KEY_W-1:0]          req_key_id,
	input  wire logic [ptbl_pkg::TIME_W-1:0]         req_time_ms,
	input  wire logic                                cfg_valid,
	input  wire logic [ptbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ptbl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                rsp_ready,
	output logic                                     rsp_valid,
	output logic                                     rsp_allowed,
	output logic [ptbl_pkg::OUT_SLOT_W-1:0]          rsp_slot_used,
	output logic                                     rsp_new_client
);

	localparam int N = ptbl_pkg::CLIENT_SLOTS;
	localparam int G = ptbl_pkg::GROUPS;

	logic [ptbl_pkg::RATE_W-1:0]   rate_q;
	logic [ptbl_pkg::TOK_W-1:0]    burst_milli_q;

	logic [ptbl_pkg::KEY_W-1:0]    key_q;
	logic [ptbl_pkg::TIME_W-1:0]   now_q;

	logic                          valid_q    [N];
	logic [ptbl_pkg::KEY_W-1:0]    key_mem    [N];
	logic [ptbl_pkg::TOK_W-1:0]    tok_mem    [N];
	logic [ptbl_pkg::TIME_W-1:0]   refill_mem [N];
	logic [ptbl_pkg::TIME_W-1:0]   seen_mem   [N];

	logic                          hit_any, free_any;
	logic [ptbl_pkg::SLOT_W-1:0]   hit_idx, vacant_idx;
	logic [ptbl_pkg::SLOT_W-1:0]   grp_idx  [G];
	logic [ptbl_pkg::TIME_W-1:0]   grp_seen [G];

	logic                          hit_any_s1, free_any_s1;
	logic [ptbl_pkg::SLOT_W-1:0]   hit_idx_s1, vacant_idx_s1;
	logic [ptbl_pkg::SLOT_W-1:0]   grp_idx_s1  [G];
	logic [ptbl_pkg::TIME_W-1:0]   grp_seen_s1 [G];

	logic [ptbl_pkg::SLOT_W-1:0]   old_idx;
	logic [ptbl_pkg::TIME_W-1:0]   old_seen;
	logic [ptbl_pkg::SLOT_W-1:0]   slot_s2;
	logic                          fresh_s2;

	logic [ptbl_pkg::TOK_W-1:0]    cur_tok;
	logic [ptbl_pkg::TIME_W-1:0]   cur_ref;
	logic [ptbl_pkg::TIME_W-1:0]   diff;
	logic [ptbl_pkg::TOK_W-1:0]    tok_s3;
	logic [ptbl_pkg::ELAPSED_W-1:0] elapsed_s3;
	logic                          pos_s3;

	logic [ptbl_pkg::TOK_W-1:0]    tok_s4;
	logic [ptbl_pkg::PROD_W-1:0]   prod_s4;
	logic                          pos_s4;

	logic [ptbl_pkg::SUM_W-1:0]    sum;
	logic [ptbl_pkg::TOK_W-1:0]    refilled, bal, new_tok;
	logic                          ok;

	logic                          rsp_valid_q;
	logic                          allowed_q, new_client_q;
	logic [ptbl_pkg::OUT_SLOT_W-1:0] slot_used_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q        <= ptbl_pkg::RATE_RESET;
			burst_milli_q <= ptbl_pkg::BURST_MILLI_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ptbl_pkg::REG_REFILL_RATE:  rate_q <= ptbl_pkg::RATE_W'(cfg_data);
				ptbl_pkg::REG_BURST_TOKENS: burst_milli_q <=
					ptbl_pkg::TOK_W'(ptbl_pkg::TOK_W'(cfg_data) * ptbl_pkg::MILLI_PER_TOKEN);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= req_key_id;
			now_q <= req_time_ms;
		end
	end

	// key match, first free slot, per-group oldest
	always_comb begin
		hit_any    = 1'b0;
		hit_idx    = '0;
		free_any   = 1'b0;
		vacant_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (valid_q[i] && key_mem[i] == key_q) begin
				hit_any = 1'b1;
				hit_idx = ptbl_pkg::SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_any   = 1'b1;
				vacant_idx = ptbl_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		for (int g = 0; g < G; g++) begin
			grp_idx[g]  = ptbl_pkg::SLOT_W'(g * ptbl_pkg::GROUP);
			grp_seen[g] = seen_mem[g * ptbl_pkg::GROUP];
			for (int j = 1; j < ptbl_pkg::GROUP; j++) begin
				if (g * ptbl_pkg::GROUP + j < N) begin
					if (seen_mem[g * ptbl_pkg::GROUP + j] < grp_seen[g]) begin
						grp_idx[g]  = ptbl_pkg::SLOT_W'(g * ptbl_pkg::GROUP + j);
						grp_seen[g] = seen_mem[g * ptbl_pkg::GROUP + j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_any_s1    <= hit_any;
			hit_idx_s1    <= hit_idx;
			free_any_s1   <= free_any;
			vacant_idx_s1 <= vacant_idx;
			for (int g = 0; g < G; g++) begin
				grp_idx_s1[g]  <= grp_idx[g];
				grp_seen_s1[g] <= grp_seen[g];
			end
		end
	end

	// oldest over group winners, lowest index on a tie
	always_comb begin
		old_idx  = grp_idx_s1[0];
		old_seen = grp_seen_s1[0];
		for (int g = 1; g < G; g++) begin
			if (grp_seen_s1[g] < old_seen) begin
				old_idx  = grp_idx_s1[g];
				old_seen = grp_seen_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			fresh_s2 <= !hit_any_s1;
			if (hit_any_s1)       slot_s2 <= hit_idx_s1;
			else if (free_any_s1) slot_s2 <= vacant_idx_s1;
			else                  slot_s2 <= old_idx;
		end
	end

	// elapsed time, saturated
	always_comb begin
		cur_tok = fresh_s2 ? burst_milli_q : tok_mem[slot_s2];
		cur_ref = fresh_s2 ? now_q : refill_mem[slot_s2];
		diff    = now_q - cur_ref;
	end

	always_ff @(posedge clk) begin
		if (cmd.delta) begin
			tok_s3     <= cur_tok;
			pos_s3     <= now_q > cur_ref;
			elapsed_s3 <= (diff > ptbl_pkg::TIME_W'(ptbl_pkg::ELAPSED_CAP)) ?
				ptbl_pkg::ELAPSED_CAP : diff[ptbl_pkg::ELAPSED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			tok_s4  <= tok_s3;
			pos_s4  <= pos_s3;
			prod_s4 <= ptbl_pkg::PROD_W'(elapsed_s3) * ptbl_pkg::PROD_W'(rate_q);
		end
	end

	// refill, cap, spend
	always_comb begin
		sum      = ptbl_pkg::SUM_W'(tok_s4) + ptbl_pkg::SUM_W'(prod_s4);
		refilled = (sum > ptbl_pkg::SUM_W'(burst_milli_q)) ? burst_milli_q :
			sum[ptbl_pkg::TOK_W-1:0];
		bal      = pos_s4 ? refilled : tok_s4;
		ok       = bal >= ptbl_pkg::MILLI_PER_TOKEN;
		new_tok  = ok ? bal - ptbl_pkg::MILLI_PER_TOKEN : bal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) valid_q[i] <= 1'b0;
		end else if (cmd.commit) begin
			valid_q[slot_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			key_mem[slot_s2]  <= key_q;
			tok_mem[slot_s2]  <= new_tok;
			seen_mem[slot_s2] <= now_q;
			if (pos_s4 || fresh_s2) refill_mem[slot_s2] <= now_q;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			allowed_q    <= ok;
			new_client_q <= fresh_s2;
			slot_used_q  <= ptbl_pkg::OUT_SLOT_W'(slot_s2);
		end
	end

	assign sts.out_full   = rsp_valid_q && !rsp_ready;
	assign rsp_valid      = rsp_valid_q;
	assign rsp_allowed    = allowed_q;
	assign rsp_slot_used  = slot_used_q;
	assign rsp_new_client = new_client_q;

endmodule

`default_nettype wire

/* hw/rtl/per_client_token_bucket_limiter_core.sv */
// A request beat is accepted only in idle; the controller then runs its five-step
// sequence (lookup, LRU pick, elapsed, multiply, commit) and returns to idle, so
// the next request is taken only once the last has committed its response.
// A commit waits while the response register still holds an untaken beat.
// Reset clears control, slot valid bits and restores refill_rate 5, burst_tokens 10.
`default_nettype none

module per_client_token_bucket_limiter_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ptbl_req_if.sink     req,
	ptbl_rsp_if.source   rsp,
	ptbl_cfg_if.sink     cfg
);

	ptbl_pkg::cmd_t cmd;
	ptbl_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	ptbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptbl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_key_id     (req.key_id),
		.req_time_ms    (req.time_ms),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_allowed    (rsp.allowed),
		.rsp_slot_used  (rsp.slot_used),
		.rsp_new_client (rsp.new_client)
	);

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath step at once");

	a_accept_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.lookup)
		else $error("accepted beat not followed by lookup");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && sts.out_full))
		else $error("commit over an untaken response beat");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("response beat without a commit");
`endif

endmodule

`default_nettype wire

/* test/per_client_token_bucket_limiter_core_test.sv */
// Self-checking bench for per_client_token_bucket_limiter_core. Directed and random requests
// run under several rate/burst settings, and a bucket table model checks every response.
// Depends on ptbl_pkg and the ptbl_req_if, ptbl_rsp_if and ptbl_cfg_if interfaces.

module per_client_token_bucket_limiter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = ptbl_pkg::CLIENT_SLOTS;
	localparam int ELAPSED_LIMIT  = ptbl_pkg::ELAPSED_CAP;
	localparam int POOL_MAX       = 24;
	localparam int PHASE_ITEMS    = 100;
	localparam int SQUEEZE_CYCLES = 300;
	localparam logic [ptbl_pkg::CFG_IDX_W-1:0] REG_SPARE = '1;

	typedef struct packed {
		logic                            allowed;
		logic [ptbl_pkg::OUT_SLOT_W-1:0] slot_used;
		logic                            new_client;
	} verdict_t;

	class bucket_scoreboard;
		logic [ptbl_pkg::RATE_W-1:0]  refill_rate;
		logic [ptbl_pkg::BURST_W-1:0] burst_tokens;
		bit                           live[SLOTS];
		logic [ptbl_pkg::KEY_W-1:0]   owner[SLOTS];
		logic [ptbl_pkg::TOK_W-1:0]   balance[SLOTS];
		logic [ptbl_pkg::TIME_W-1:0]  refilled_at[SLOTS];
		logic [ptbl_pkg::TIME_W-1:0]  seen_at[SLOTS];
		verdict_t                     pending[$];
		int errors, n_requests, n_allowed, n_fresh, n_evicted;

		function new();
			refill_rate = ptbl_pkg::RATE_RESET;
			burst_tokens = ptbl_pkg::BURST_W'(10);
			foreach (live[i]) live[i] = 0;
		endfunction

		function void write_reg(logic [ptbl_pkg::CFG_IDX_W-1:0] idx,
			logic [ptbl_pkg::CFG_DATA_W-1:0] data);
			if (idx == ptbl_pkg::REG_REFILL_RATE)
				refill_rate = data;
			else if (idx == ptbl_pkg::REG_BURST_TOKENS)
				burst_tokens = data;
		endfunction

		function void take_request(logic [ptbl_pkg::KEY_W-1:0] key,
			logic [ptbl_pkg::TIME_W-1:0] now);
			int hit, vacant, oldest, s;
			logic [ptbl_pkg::TIME_W-1:0] lru_seen;
			longint unsigned cap_milli, elapsed, total;
			verdict_t v;
			cap_milli = burst_tokens;
			cap_milli = cap_milli * ptbl_pkg::MILLI_PER_TOKEN;
			hit = -1;
			vacant = -1;
			oldest = -1;
			lru_seen = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (hit < 0) begin
					if (live[i]) begin
						if (owner[i] == key)
							hit = i;
						else if (oldest < 0 || seen_at[i] < lru_seen) begin
							lru_seen = seen_at[i];
							oldest = i;
						end
					end else if (vacant < 0) begin
						vacant = i;
					end
				end
			end
			v.new_client = (hit < 0);
			if (hit >= 0) begin
				s = hit;
			end else begin
				s = (vacant >= 0) ? vacant : oldest;
				if (vacant < 0) n_evicted++;
				n_fresh++;
				live[s] = 1;
				owner[s] = key;
				balance[s] = cap_milli[ptbl_pkg::TOK_W-1:0];
				refilled_at[s] = now;
			end
			// refill only on forward time; a late request leaves the refill mark alone
			if (now > refilled_at[s]) begin
				elapsed = now - refilled_at[s];
				if (elapsed > ELAPSED_LIMIT) elapsed = ELAPSED_LIMIT;
				total = balance[s] + elapsed * refill_rate;
				if (total > cap_milli) total = cap_milli;
				balance[s] = total[ptbl_pkg::TOK_W-1:0];
				refilled_at[s] = now;
			end
			seen_at[s] = now;
			v.allowed = (balance[s] >= ptbl_pkg::MILLI_PER_TOKEN);
			if (v.allowed) begin
				balance[s] -= ptbl_pkg::MILLI_PER_TOKEN;
				n_allowed++;
			end
			v.slot_used = ptbl_pkg::OUT_SLOT_W'(s);
			n_requests++;
			pending.push_back(v);
		endfunction

		function void check_verdict(logic allowed, logic [ptbl_pkg::OUT_SLOT_W-1:0] slot_used,
			logic new_client);
			verdict_t want;
			if (pending.size() == 0) begin
				$display("%0t: response with none pending: allowed=%0b slot_used=%0d new_client=%0b",
					$time, allowed, slot_used, new_client);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (allowed !== want.allowed) begin
				$display("%0t: allowed expected %0b actual %0b", $time, want.allowed, allowed);
				errors++;
			end
			if (slot_used !== want.slot_used) begin
				$display("%0t: slot_used expected %0d actual %0d", $time, want.slot_used, slot_used);
				errors++;
			end
			if (new_client !== want.new_client) begin
				$display("%0t: new_client expected %0b actual %0b", $time, want.new_client,
					new_client);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;

	ptbl_req_if req();
	ptbl_rsp_if rsp();
	ptbl_cfg_if cfg();

	per_client_token_bucket_limiter_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	bucket_scoreboard ledger = new();

	bit                          sender_calm;
	bit                          receiver_calm;
	bit                          squeeze_request;
	int                          stall_left;
	int                          n_settings;
	logic [ptbl_pkg::TIME_W-1:0] clock_ms;
	logic [ptbl_pkg::KEY_W-1:0]  key_pool[POOL_MAX];

	always #5 clk = ~clk;

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function logic [ptbl_pkg::TIME_W-1:0] next_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return clock_ms;
		else if (r < 80)
			clock_ms += $urandom_range(1, 300);
		else if (r < 90)
			clock_ms += $urandom_range(301, 5000);
		else if (r < 93)
			clock_ms += $urandom_range(ELAPSED_LIMIT - 2, ELAPSED_LIMIT + 2);
		else if (r < 96)
			clock_ms += $urandom_range(ELAPSED_LIMIT + 3, 4 * ELAPSED_LIMIT);
		else if (r < 99)
			return clock_ms - $urandom_range(1, 1000);
		return clock_ms;
	endfunction

	task automatic send_request(input logic [ptbl_pkg::KEY_W-1:0] key,
		input logic [ptbl_pkg::TIME_W-1:0] t);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req.valid = 0;
		end
		@(negedge clk);
		req.valid = 1;
		req.key_id = key;
		req.time_ms = t;
		do @(posedge clk); while (!req.ready);
		ledger.take_request(key, t);
	endtask

	task automatic write_reg(input logic [ptbl_pkg::CFG_IDX_W-1:0] idx,
		input logic [ptbl_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid = 1;
		cfg.index = idx;
		cfg.data = data;
		do @(posedge clk); while (!cfg.ready);
		ledger.write_reg(idx, data);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid = 0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(input int rate, input int burst, input int pool);
		logic [ptbl_pkg::KEY_W-1:0] key;
		drain();
		write_reg(ptbl_pkg::REG_REFILL_RATE, ptbl_pkg::CFG_DATA_W'(rate));
		write_reg(ptbl_pkg::REG_BURST_TOKENS, ptbl_pkg::CFG_DATA_W'(burst));
		n_settings++;
		repeat (PHASE_ITEMS) begin
			key = ($urandom_range(0, 99) < 3) ? $urandom : key_pool[$urandom_range(0, pool - 1)];
			send_request(key, next_time());
		end
	endtask

	always @(negedge clk) begin
		if (squeeze_request) begin
			squeeze_request = 0;
			rsp.ready = 0;
			repeat (SQUEEZE_CYCLES) @(negedge clk);
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready = 0;
		end else if (receiver_calm || $urandom_range(0, 99) < 70) begin
			rsp.ready = 1;
		end else begin
			stall_left = pick_gap();
			rsp.ready = 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			ledger.check_verdict(rsp.allowed, rsp.slot_used, rsp.new_client);
	end

	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		req.valid = 0;
		req.key_id = '0;
		req.time_ms = '0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.data = '0;
		rsp.ready = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// new client, hit, second client, late request, saturated elapsed time
		send_request(32'h0, 48'd1000);
		send_request(32'h0, 48'd1000);
		send_request(32'hFFFF_FFFF, 48'd0);
		send_request(32'h0, 48'd500);
		send_request(32'h0, '1);
		// fill the table at one time stamp, then evict the oldest and break a tie
		for (int k = 2; k < SLOTS; k++) send_request(k, 48'd5);
		send_request(32'd16, 48'd5);
		send_request(32'd17, 48'd5);
		clock_ms = 5;

		drain();
		n_settings++;
		repeat (PHASE_ITEMS) send_request(key_pool[$urandom_range(0, 11)], next_time());

		// hold the response side so the block backs up
		sender_calm = 1;
		squeeze_request = 1;
		run_phase(1000, 1000, 12);
		sender_calm = 0;

		run_phase(1, 1, POOL_MAX);
		drain();
		write_reg(REG_SPARE, '1);
		run_phase(0, 3, 12);
		run_phase(1023, 0, POOL_MAX);
		run_phase(0, 0, 12);
		clock_ms = {16'($urandom), 32'($urandom)};
		run_phase(1023, 1023, POOL_MAX);
		sender_calm = 1;
		receiver_calm = 1;
		run_phase(200, 2, 16);
		sender_calm = 0;
		receiver_calm = 0;
		run_phase(37, 5, 20);
		run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), POOL_MAX);
		drain();

		$display("Ran %0d requests under %0d rate/burst settings: %0d allowed, %0d refused.",
			ledger.n_requests, n_settings, ledger.n_allowed,
			ledger.n_requests - ledger.n_allowed);
		$display("%0d clients claimed a slot, %0d of them by evicting the least recently seen.",
			ledger.n_fresh, ledger.n_evicted);
		if (ledger.errors == 0 && ledger.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ptbl_pkg.sv
hw/rtl/ptbl_req_if.sv
hw/rtl/ptbl_rsp_if.sv
hw/rtl/ptbl_cfg_if.sv
hw/rtl/ptbl_ctrl.sv
hw/rtl/ptbl_dp.sv
hw/rtl/per_client_token_bucket_limiter_core.sv
test/per_client_token_bucket_limiter_core_test.sv
